@@ src/i2cws_pkg.sv @@
package i2cws_pkg;

    // frame sent after the address byte: r, g, b, checksum
    localparam int FRAME_DATA_BYTES = 4;
    localparam int FRAME_DEPTH      = 4;
    localparam int FRAME_IDX_W      = 2;
    localparam int COUNT_W          = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

    // address byte after reset, read/write bit included
    localparam logic [7:0] ADDR_RESET = 8'h30;
    localparam logic [7:0] CSUM_BASE  = 8'hFF;

    // bus controller status codes
    localparam logic [7:0] ST_START_SENT = 8'h08;
    localparam logic [7:0] ST_ADDR_ACK   = 8'h18;
    localparam logic [7:0] ST_DATA_SENT  = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_ADDR_NACK  = 8'h20;

    // command codes
    localparam logic CMD_SEND   = 1'b0;
    localparam logic CMD_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_STARTED  = 3'd1,
        PH_DATA_ACK = 3'd2,
        PH_DONE     = 3'd3,
        PH_NACK     = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NACK_DATA = 2'd1,
        ERR_NACK_ADDR = 2'd2
    } t_err;

    typedef struct packed {
        logic       command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] status_code;
    } t_in_item;

    typedef struct packed {
        logic       busy_reject;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       request_start;
        logic       request_stop;
        logic       clear_interrupt;
        logic       clear_start;
        logic [2:0] master_state;
        logic [1:0] last_error;
    } t_out_item;

endpackage

@@ src/i2c_master_write_sequencer.sv @@
// channel | direction | signals                            | payload
// in      | input     | i_in_valid / o_in_ready            | i_in_data (t_in_item)
// out     | output    | o_out_valid / i_out_ready          | o_out_data (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready          | i_cfg_data (address byte)
//
// one transaction a cycle sustained while the result side is not stalled; the
// result passes through the input register and then the result register
// around the decode
// reset is synchronous, active low; the address byte returns to 0x30
// a stalled result holds in the output register while one more transaction
// waits in the input register; the input side stalls only when both are full
module i2c_master_write_sequencer
    import i2cws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic      r_in_vld;
    t_in_item  r_in_data;
    logic      r_out_vld;
    t_out_item r_out_data;
    logic [7:0] r_addr_byte;

    logic      w_step;
    logic      w_in_acc;
    t_out_item w_result;

    // pipeline flow control
    assign w_step      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_step;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // address byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_byte <= ADDR_RESET;
        end else if (i_cfg_valid) begin
            r_addr_byte <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_data <= i_in_data;
        end
    end

    // decode and sequencer state
    i2cws_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_in_data),
        .i_addr_byte (r_addr_byte),
        .o_result    (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= w_result;
        end
    end

`ifndef SYNTH
    // input side stalls only with the input register full
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_vld && r_out_vld && !i_out_ready)
        else $error("input stalled without backpressure");

    // a step always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_vld)
        else $error("stepped transaction lost");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !w_step)
        else $error("result overwritten while stalled");
`endif

endmodule

@@ src/i2cws_core.sv @@
module i2cws_core
    import i2cws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  logic [7:0] i_addr_byte,
    output t_out_item o_result
);

    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_sent_count, n_sent_count;
    logic [7:0]           r_frame [FRAME_DEPTH];
    logic [7:0]           n_frame [FRAME_DEPTH];
    t_err                 r_err, n_err;

    logic                 w_busy;
    logic                 w_more;
    logic [COUNT_W-1:0]   w_count_inc;
    logic [7:0]           w_frame_cur;
    logic [7:0]           w_sum;

    // shared decode
    assign w_busy      = (i_item.command == CMD_SEND) &&
                         ((r_phase == PH_STARTED) || (r_phase == PH_DATA_ACK));
    assign w_more      = 32'(r_sent_count) < FRAME_DATA_BYTES;
    assign w_count_inc = (r_sent_count != COUNT_MAX) ? r_sent_count + 1'b1 : r_sent_count;
    assign w_frame_cur = (32'(r_sent_count) < FRAME_DEPTH) ?
                         r_frame[r_sent_count[FRAME_IDX_W-1:0]] : 8'h00;
    assign w_sum       = i_item.red + i_item.green + i_item.blue;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_sent_count = r_sent_count;
        n_frame      = r_frame;
        n_err        = r_err;
        if (i_item.command == CMD_SEND) begin
            if (!w_busy) begin
                n_frame[0]   = i_item.red;
                n_frame[1]   = i_item.green;
                n_frame[2]   = i_item.blue;
                n_frame[3]   = CSUM_BASE - w_sum;
                n_phase      = PH_IDLE;
                n_sent_count = '0;
            end
        end else begin
            unique case (i_item.status_code)
                ST_START_SENT: begin
                    n_phase = PH_STARTED;
                end
                ST_ADDR_ACK: begin
                    if (r_phase == PH_STARTED) begin
                        n_sent_count = w_count_inc;
                        n_phase      = PH_DATA_ACK;
                    end
                end
                ST_DATA_SENT: begin
                    if (w_more) begin
                        n_sent_count = w_count_inc;
                        n_phase      = PH_DATA_ACK;
                    end else begin
                        n_phase = PH_DONE;
                    end
                    n_err = ERR_NONE;
                end
                ST_DATA_NACK: begin
                    n_phase = PH_NACK;
                    n_err   = ERR_NACK_DATA;
                end
                ST_ADDR_NACK: begin
                    n_phase = PH_NACK;
                    n_err   = ERR_NACK_ADDR;
                end
                default: begin
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        o_result              = '0;
        o_result.master_state = n_phase;
        o_result.last_error   = n_err;
        if (i_item.command == CMD_SEND) begin
            if (w_busy) begin
                o_result.busy_reject = 1'b1;
            end else begin
                o_result.request_stop    = 1'b1;
                o_result.clear_interrupt = 1'b1;
                o_result.request_start   = 1'b1;
            end
        end else begin
            o_result.clear_interrupt = 1'b1;
            unique case (i_item.status_code)
                ST_START_SENT: begin
                    o_result.tx_valid    = 1'b1;
                    o_result.tx_byte     = i_addr_byte;
                    o_result.clear_start = 1'b1;
                end
                ST_ADDR_ACK: begin
                    if (r_phase == PH_STARTED) begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_byte  = r_frame[0];
                    end
                end
                ST_DATA_SENT: begin
                    if (w_more) begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_byte  = w_frame_cur;
                    end else begin
                        o_result.request_stop = 1'b1;
                    end
                end
                ST_DATA_NACK, ST_ADDR_NACK: begin
                    o_result.request_stop = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer state, updated once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_sent_count <= '0;
            r_err        <= ERR_NONE;
            for (int i = 0; i < FRAME_DEPTH; i++) begin
                r_frame[i] <= '0;
            end
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_sent_count <= n_sent_count;
            r_err        <= n_err;
            r_frame      <= n_frame;
        end
    end

`ifndef SYNTH
    // phase code stays within the defined states
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_NACK)
        else $error("phase out of range");

    // state only moves on a step
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_sent_count) && $stable(r_err))
        else $error("state changed without a step");

    // a refused send requests nothing on the bus
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.busy_reject |-> !o_result.tx_valid && !o_result.request_start &&
                                 !o_result.request_stop && !o_result.clear_interrupt)
        else $error("busy reject with bus request");

    // a data byte is only loaded while the transfer is in flight
    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.tx_valid && !o_result.clear_start) |=>
            (r_phase == PH_DATA_ACK))
        else $error("frame byte loaded outside data phase");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import i2cws_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data  = '0;

    // expected bus actions, oldest first
    t_out_item  pending_actions[$];

    // sequencer state as the testbench tracks it
    t_phase     seq_phase;
    logic [2:0] seq_count;
    logic [7:0] seq_frame[FRAME_DEPTH];
    t_err       seq_error;
    logic [7:0] addr_byte;

    int         items_sent;
    int         mismatches;
    bit         no_idle;

    i2c_master_write_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result backpressure
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= 25);
    end

    // advance the tracked state by one transaction and return its bus action
    function automatic t_out_item next_bus_action(t_in_item it);
        t_out_item r;
        r = '0;
        if (it.command == CMD_SEND) begin
            if (seq_phase == PH_STARTED || seq_phase == PH_DATA_ACK) begin
                r.busy_reject = 1'b1;
            end else begin
                seq_frame[0] = it.red;
                seq_frame[1] = it.green;
                seq_frame[2] = it.blue;
                seq_frame[3] = CSUM_BASE - 8'(it.red + it.green + it.blue);
                r.request_stop    = 1'b1;
                r.clear_interrupt = 1'b1;
                r.request_start   = 1'b1;
                seq_phase = PH_IDLE;
                seq_count = '0;
            end
        end else begin
            r.clear_interrupt = 1'b1;
            case (it.status_code)
                ST_START_SENT: begin
                    r.tx_valid    = 1'b1;
                    r.tx_byte     = addr_byte;
                    r.clear_start = 1'b1;
                    seq_phase     = PH_STARTED;
                end
                ST_ADDR_ACK: begin
                    if (seq_phase == PH_STARTED) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = seq_frame[0];
                        if (seq_count < COUNT_MAX) seq_count = seq_count + 3'd1;
                        seq_phase  = PH_DATA_ACK;
                    end
                end
                ST_DATA_SENT: begin
                    if (int'(seq_count) < FRAME_DATA_BYTES) begin
                        r.tx_valid = 1'b1;
                        // bytes past the stored frame go out as zero
                        r.tx_byte  = (int'(seq_count) < FRAME_DEPTH) ?
                                     seq_frame[seq_count[FRAME_IDX_W-1:0]] : 8'h00;
                        if (seq_count < COUNT_MAX) seq_count = seq_count + 3'd1;
                        seq_phase  = PH_DATA_ACK;
                    end else begin
                        r.request_stop = 1'b1;
                        seq_phase      = PH_DONE;
                    end
                    seq_error = ERR_NONE;
                end
                ST_DATA_NACK: begin
                    r.request_stop = 1'b1;
                    seq_phase      = PH_NACK;
                    seq_error      = ERR_NACK_DATA;
                end
                ST_ADDR_NACK: begin
                    r.request_stop = 1'b1;
                    seq_phase      = PH_NACK;
                    seq_error      = ERR_NACK_ADDR;
                end
                default: ;
            endcase
        end
        r.master_state = seq_phase;
        r.last_error   = seq_error;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_actions.size() == 0) begin
                $error("result with no expectation waiting: %0h", o_out_data);
                mismatches++;
            end else begin
                want = pending_actions.pop_front();
                check_field("busy_reject", want.busy_reject, o_out_data.busy_reject);
                check_field("tx_valid", want.tx_valid, o_out_data.tx_valid);
                check_field("tx_byte", want.tx_byte, o_out_data.tx_byte);
                check_field("request_start", want.request_start, o_out_data.request_start);
                check_field("request_stop", want.request_stop, o_out_data.request_stop);
                check_field("clear_interrupt", want.clear_interrupt,
                            o_out_data.clear_interrupt);
                check_field("clear_start", want.clear_start, o_out_data.clear_start);
                check_field("master_state", want.master_state, o_out_data.master_state);
                check_field("last_error", want.last_error, o_out_data.last_error);
            end
        end
    end

    // one input transaction; valid stays high afterwards for back-to-back items
    task automatic send_item(t_in_item it);
        if (!no_idle && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 25) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_actions.push_back(next_bus_action(it));
        items_sent++;
    endtask

    function automatic t_in_item status_item(logic [7:0] code);
        t_in_item it;
        it             = t_in_item'(33'({$urandom, $urandom}));
        it.command     = CMD_STATUS;
        it.status_code = code;
        return it;
    endfunction

    function automatic t_in_item color_item(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_in_item it;
        it         = t_in_item'(33'({$urandom, $urandom}));
        it.command = CMD_SEND;
        it.red     = r;
        it.green   = g;
        it.blue    = b;
        return it;
    endfunction

    // sender holds off until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_address(logic [7:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        addr_byte = value;
    endtask

    // full frame, refused sends mid transfer, nacks, unknown codes
    task automatic test_directed_frames();
        send_item(color_item(8'hFF, 8'hFF, 8'hFF));
        send_item(status_item(ST_START_SENT));
        send_item(color_item(8'h12, 8'h34, 8'h56));
        send_item(status_item(ST_ADDR_ACK));
        send_item(color_item(8'h00, 8'h00, 8'h00));
        repeat (3) send_item(status_item(ST_DATA_SENT));
        send_item(status_item(ST_DATA_SENT));
        send_item(status_item(ST_DATA_SENT));
        send_item(color_item(8'h00, 8'h00, 8'h00));
        send_item(status_item(ST_START_SENT));
        send_item(status_item(ST_ADDR_NACK));
        send_item(color_item(8'h01, 8'h02, 8'h03));
        send_item(status_item(ST_START_SENT));
        send_item(status_item(ST_ADDR_ACK));
        send_item(status_item(ST_DATA_NACK));
        send_item(status_item(8'h00));
        send_item(status_item(8'hFF));
        send_item(status_item(ST_ADDR_ACK));
    endtask

    // repeated start/address ack pushes the byte counter past the frame length
    task automatic test_count_saturation();
        repeat (5) begin
            send_item(status_item(ST_START_SENT));
            send_item(status_item(ST_ADDR_ACK));
        end
        send_item(status_item(ST_DATA_SENT));
    endtask

    // mostly complete frames, some broken by a nack, plus random noise
    task automatic test_random_traffic(int target);
        logic [7:0] known[5];
        int         last;
        known = '{ST_START_SENT, ST_ADDR_ACK, ST_DATA_SENT, ST_DATA_NACK, ST_ADDR_NACK};
        last  = items_sent + target;
        while (items_sent < last) begin
            if ($urandom_range(99) < 70) begin
                send_item(color_item(8'($urandom), 8'($urandom), 8'($urandom)));
                send_item(status_item(ST_START_SENT));
                if ($urandom_range(99) < 10) begin
                    send_item(status_item(ST_ADDR_NACK));
                    continue;
                end
                send_item(status_item(ST_ADDR_ACK));
                for (int k = 0; k < FRAME_DATA_BYTES; k++) begin
                    if ($urandom_range(99) < 5) begin
                        send_item(status_item(ST_DATA_NACK));
                        break;
                    end
                    send_item(status_item(ST_DATA_SENT));
                end
            end else if ($urandom_range(1) == 0) begin
                send_item(status_item(known[$urandom_range(4)]));
            end else begin
                send_item(t_in_item'(33'({$urandom, $urandom})));
            end
        end
    endtask

    // watchdog
    initial begin
        #1000000;
        $display("[i2c_master_write_sequencer] ERROR");
        $finish;
    end

    initial begin
        seq_phase  = PH_IDLE;
        seq_count  = '0;
        seq_frame  = '{default: 8'h00};
        seq_error  = ERR_NONE;
        addr_byte  = ADDR_RESET;
        items_sent = 0;
        mismatches = 0;
        no_idle    = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_count_saturation();
        test_random_traffic(300);
        drain_results();
        test_random_traffic(50);

        write_address(8'h00);
        test_random_traffic(350);

        write_address(8'hFF);
        no_idle = 1'b1;
        test_random_traffic(350);
        no_idle = 1'b0;

        write_address(8'($urandom_range(255)));
        test_random_traffic(350);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_actions.size() == 0) begin
            $display("[i2c_master_write_sequencer] OK");
        end else begin
            $display("[i2c_master_write_sequencer] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/i2cws_pkg.sv
src/i2cws_core.sv
src/i2c_master_write_sequencer.sv
tb/tb.sv
